### src/lrce_pkg.sv
// Shared constants and tables for the LED ring chaser engine.
`timescale 1ns / 1ps

package lrce_pkg;

  localparam int LRCE_LED_COUNT_DEF = 32;
  localparam int LED_INDEX_W = 5;
  localparam int LED_COLOR_W = 16;

  localparam logic [LED_COLOR_W-1:0] PAT3 [3] = '{16'h000F, 16'h001F, 16'h000F};
  localparam logic [LED_COLOR_W-1:0] PAT5 [5] = '{16'h000A, 16'h0015, 16'h001F,
                                                  16'h0015, 16'h000A};

  localparam logic [7:0] COLOR_STEP = 8'h10;

endpackage

### src/lrce_ifs.sv
// Valid/ready channel interfaces for tick items and LED color items.
`timescale 1ns / 1ps

interface lrce_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lrce_out_if
  import lrce_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [LED_INDEX_W-1:0] led_index;
  logic [LED_COLOR_W-1:0] led_color;
  logic                   last_led;

  modport source (output valid, output led_index, output led_color, output last_led,
                  input ready);
  modport sink (input valid, input led_index, input led_color, input last_led,
                output ready);
endinterface

### src/lrce_ring_mem.sv
// Single-port-write, registered-read memory holding the LED ring colors.
`timescale 1ns / 1ps

module lrce_ring_mem
  import lrce_pkg::*;
#(
  parameter int DEPTH = LRCE_LED_COUNT_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [LED_COLOR_W-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [LED_COLOR_W-1:0] rdata
);

  logic [LED_COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lrce_color_step.sv
// Color-change step: bumps red, carries into green, then into blue.
`timescale 1ns / 1ps

module lrce_color_step
  import lrce_pkg::*;
(
  input  logic [LED_COLOR_W-1:0] color_in,
  output logic [LED_COLOR_W-1:0] color_out
);

  logic [7:0] r8;
  logic [7:0] g8;
  logic [7:0] b8;
  logic [7:0] r_new;
  logic [7:0] g_new;
  logic [7:0] b_new;

  always_comb begin
    r8 = {color_in[15:11], 3'b000};
    g8 = {color_in[10:5], 2'b00};
    b8 = {color_in[4:0], 3'b000};
    r_new = r8 + COLOR_STEP;
    g_new = (r_new == 8'd0) ? (g8 + COLOR_STEP) : g8;
    b_new = (g_new == 8'd0) ? (b8 + COLOR_STEP) : b8;
    color_out = {r_new[7:3], g_new[7:2], b_new[7:3]};
  end

endmodule

### src/led_ring_chaser_engine.sv
// Top level of the LED ring chaser engine: sequencer, ring pointer and output stage.
`timescale 1ns / 1ps

// The tick channel takes one item per frame; its restart bit reloads the pattern first.
// The leds channel then delivers LED_COUNT items, LED 0 first, with last_led on the
// final one. The cfg_we/cfg_wdata pair writes pattern_mode; the user must write it
// only while the block is idle, as the block itself does not enforce this. Rotation
// moves a base pointer into the ring memory rather than the colors. A plain tick reads
// the ring through the single memory read port, which gives one LED per cycle while
// the receiver does not stall. A restart first writes the pattern into every LED,
// and a color-change tick first reads and rewrites each LED through the one
// color-step unit.
// The tick ready is high only while the sequencer is idle; the final item of a
// frame may still sit in the output register when the next tick is accepted.
// After reset the block clears every ring entry to zero before it is ready.
// When the receiver stalls, the output register and the read stage hold and the
// memory read pointer stops, so no item is lost or repeated.

module led_ring_chaser_engine
  import lrce_pkg::*;
#(
  parameter int LED_COUNT = LRCE_LED_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  lrce_in_if.sink           tick,
  lrce_out_if.source        leds
);

  localparam int AW = $clog2(LED_COUNT);
  localparam int CW = $clog2(LED_COUNT + 1);
  localparam int PW = $clog2(2 * LED_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SHRD  = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_ROT   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]    state;
  logic          pattern_mode;
  logic [AW-1:0] idx;
  logic [1:0]    m3;
  logic [2:0]    m5;
  logic [AW-1:0] offset;
  logic [PW-1:0] phase;
  logic [1:0]    pass_count;
  logic [CW-1:0] issue_cnt;
  logic          s1_vld;
  logic [AW-1:0] s1_idx;

  logic                   mem_we;
  logic [LED_COLOR_W-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [LED_COLOR_W-1:0] mem_rdata;
  logic [LED_COLOR_W-1:0] stepped;
  logic                   advance;
  logic                   issue_done;
  logic [AW:0]            addr_sum;
  logic [6:0]             s1_idx_ext;
  logic                   idx_last;

  lrce_ring_mem #(
    .DEPTH(LED_COUNT),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(idx),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  lrce_color_step u_step (
    .color_in(mem_rdata),
    .color_out(stepped)
  );

  assign tick.ready = (state == S_IDLE);
  assign advance    = !leds.valid || leds.ready;
  assign issue_done = (issue_cnt == CW'(LED_COUNT));
  assign idx_last   = (idx == AW'(LED_COUNT - 1));
  assign addr_sum   = {1'b0, issue_cnt[AW-1:0]} + {1'b0, offset};
  assign s1_idx_ext = 7'(s1_idx);

  always_comb begin
    if (state == S_SHRD) begin
      mem_raddr = idx;
    end else if (addr_sum >= (AW + 1)'(LED_COUNT)) begin
      mem_raddr = AW'(addr_sum - (AW + 1)'(LED_COUNT));
    end else begin
      mem_raddr = addr_sum[AW-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_LOAD: begin
        mem_we    = 1'b1;
        mem_wdata = pattern_mode ? PAT5[m5] : PAT3[m3];
      end
      S_SHRD: begin
        mem_re = 1'b1;
      end
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_wdata = stepped;
      end
      S_EMIT: begin
        mem_re = advance && !issue_done;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= 1'b0;
    end else if (cfg_we) begin
      pattern_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      m3         <= '0;
      m5         <= '0;
      offset     <= '0;
      phase      <= '0;
      pass_count <= 2'd1;
      issue_cnt  <= '0;
      s1_vld     <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx_last) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (tick.valid) begin
            idx <= '0;
            m3  <= '0;
            m5  <= '0;
            if (tick.restart) begin
              state <= S_LOAD;
            end else begin
              state <= S_CHK;
            end
          end
        end
        S_LOAD: begin
          idx <= idx + AW'(1);
          m3  <= (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
          m5  <= (m5 == 3'd4) ? 3'd0 : m5 + 3'd1;
          if (idx_last) begin
            idx        <= '0;
            offset     <= '0;
            phase      <= '0;
            pass_count <= 2'd1;
            state      <= S_CHK;
          end
        end
        S_CHK: begin
          if (phase == '0 && pattern_mode && pass_count == 2'd2) begin
            pass_count <= 2'd0;
            idx        <= '0;
            state      <= S_SHRD;
          end else begin
            state <= S_ROT;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          idx <= idx + AW'(1);
          if (idx_last) begin
            idx   <= '0;
            state <= S_ROT;
          end else begin
            state <= S_SHRD;
          end
        end
        S_ROT: begin
          if (phase < PW'(LED_COUNT)) begin
            offset <= (offset == AW'(LED_COUNT - 1)) ? '0 : offset + AW'(1);
          end else begin
            offset <= (offset == '0) ? AW'(LED_COUNT - 1) : offset - AW'(1);
          end
          if (phase == PW'(2 * LED_COUNT - 1)) begin
            phase      <= '0;
            pass_count <= pass_count + 2'd1;
          end else begin
            phase <= phase + PW'(1);
          end
          issue_cnt <= '0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (advance) begin
            if (!issue_done) begin
              s1_vld    <= 1'b1;
              issue_cnt <= issue_cnt + CW'(1);
            end else begin
              s1_vld <= 1'b0;
            end
          end
          if (issue_done && !s1_vld) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && advance && !issue_done) begin
      s1_idx <= issue_cnt[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leds.valid <= 1'b0;
    end else if (advance) begin
      leds.valid <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld) begin
      leds.led_index <= s1_idx_ext[LED_INDEX_W-1:0];
      leds.led_color <= mem_rdata;
      leds.last_led  <= (s1_idx == AW'(LED_COUNT - 1));
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    tick.ready |-> !s1_vld)
    else $error("read stage busy while idle");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PW'(2 * LED_COUNT - 1))
    else $error("tick phase out of range");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    offset <= AW'(LED_COUNT - 1))
    else $error("ring offset out of range");

  a_restart_loads: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready && tick.restart) |=> state == S_LOAD)
    else $error("restart item did not start a pattern load");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= CW'(LED_COUNT))
    else $error("emit counter overran the ring");
`endif

endmodule
